// ----- hw/rtl/rrtv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, constants and the quarter-wave sine table for the
// rotated rectangle vertex expander. Depends on nothing.
package rrtv_pkg;

  // Sizing of the block.
  localparam int MAX_VERTICES     = 4096;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int VERTS_PER_RECT   = 6;

  localparam int COUNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int VIDX_W     = $clog2(VERTS_PER_RECT);
  localparam int PHASE_W    = 14;
  localparam int PHASE_PROD_W = PHASE_W + SINE_IDX_W + 1;

  // Field widths.
  localparam int WORLD_W = 24;
  localparam int LEN_W   = 24;
  localparam int SCALE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int COLOR_W = 16;
  localparam int NDC_W   = 16;
  localparam int SLOT_W  = 12;
  localparam int CFG_W   = 24;

  // Datapath widths.
  localparam int MUL_A_W     = 35;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int HALF_PROD_W = LEN_W + SCALE_W;
  localparam int HALF_W      = 31;
  localparam int SUM_W       = 50;
  localparam int TRIG_W      = 17;
  localparam int STEP_W      = 4;

  localparam logic [CFG_W-1:0] INV_W_RESET = 24'd41943;
  localparam logic [CFG_W-1:0] INV_H_RESET = 24'd55924;

  localparam logic [TRIG_W-1:0] SINE_ONE = 17'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [HALF_PROD_W:0] HALF_ROUND = (HALF_PROD_W + 1)'(256);
  localparam logic [14:0] ROT_ROUND = 15'h4000;
  localparam logic signed [PROD_W-1:0] NDC_ROUND = PROD_W'(131072);
  localparam logic signed [NDC_W-1:0] NDC_POS_SAT = 16'sh7fff;
  localparam logic signed [NDC_W-1:0] NDC_NEG_SAT = 16'sh8000;

  typedef logic signed [WORLD_W-1:0] world_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic signed [NDC_W-1:0]   ndc_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [CFG_W-1:0]          inv_t;
  typedef logic [VIDX_W-1:0]         vidx_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [1:0]                corner_t;
  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [HALF_W-1:0]         half_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_DRAW  = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_INV_HALF_WORLD_WIDTH  = 1'b0,
    REG_INV_HALF_WORLD_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT,
    ST_DROP
  } fsm_state_t;

  typedef struct packed {
    action_t action;
    world_t  center_x;
    world_t  center_y;
    angle_t  angle;
    len_t    width;
    len_t    height;
    scale_t  scale_x;
    scale_t  scale_y;
    color_t  red_in;
    color_t  green_in;
    color_t  blue_in;
  } rect_t;

  typedef struct packed {
    ndc_t   ndc_x;
    ndc_t   ndc_y;
    color_t red_out;
    color_t green_out;
    color_t blue_out;
    slot_t  vertex_slot;
    logic   last_of_rect;
    logic   dropped;
  } vert_t;

  // Two triangles share the diagonal from corner 0 to corner 2.
  localparam corner_t CORNER_ORDER [VERTS_PER_RECT] =
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

  typedef logic [SINE_TABLE_DEPTH-1:0][TRIG_W-1:0] sine_rom_t;

  // Quarter-wave sine in Q1.15, built at elaboration from an eleventh-order
  // nested Taylor series in Q2.30. The top point (a full quarter turn) is
  // not stored; it reads as exactly one.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      r  = (s + 64'd16384) >> 15;
      rom[k] = (r > 64'd32768) ? SINE_ONE : r[TRIG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hw/rtl/rrtv_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for rectangle beats in and vertex beats out.
// Depends on rrtv_pkg for the payload structs.
interface rrtv_rect_if;
  import rrtv_pkg::*;
  logic  valid;
  logic  ready;
  rect_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrtv_vert_if;
  import rrtv_pkg::*;
  logic  valid;
  logic  ready;
  vert_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rrtv_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on rrtv_pkg for operand and product widths.
module rrtv_mul (
  input  logic           clk,
  input  rrtv_pkg::mul_a_t a,
  input  rrtv_pkg::mul_b_t b,
  output rrtv_pkg::prod_t  p
);
  import rrtv_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- hw/rtl/rotated_rect_to_triangle_vertices.sv -----
`timescale 1ns / 1ps
// Top level of the rotated rectangle to triangle vertex expander.
// Depends on rrtv_pkg, rrtv_if.sv (channel interfaces) and rrtv_mul.
//
//   channel  dir  payload                                         handshake
//   -------  ---  ----------------------------------------------  ---------
//   rect     in   action, center, angle, size, scale, colour      valid/ready
//   vert     out  ndc x/y, colour, vertex_slot, last, dropped     valid/ready
//   cfg      in   register index and 24-bit data                  write enable
//
// A draw beat is accepted, then the single shared multiplier forms 14 products
// (two half sizes, four rotation terms, eight NDC scalings), then six output
// beats go out as the sink takes them. A frame beat is only accepted; an
// overflowing rectangle yields a single drop beat.
// Reset is synchronous and clears the vertex count and both reciprocals to
// their defaults. The output register lets a new rectangle be accepted while
// the final vertex of the previous one waits for the sink.
module rotated_rect_to_triangle_vertices (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  rrtv_pkg::cfg_reg_t        cfg_index,
  input  logic [rrtv_pkg::CFG_W-1:0] cfg_data,
  rrtv_rect_if.sink                 rect,
  rrtv_vert_if.source               vert
);
  import rrtv_pkg::*;

  // Sequencer steps: the step at which each product is issued to the
  // multiplier. The multiplier registers the product before it is consumed.
  localparam step_t ST_MUL_WX = 4'd0;   // width * scale_x
  localparam step_t ST_MUL_HY = 4'd1;   // height * scale_y
  localparam step_t ST_MUL_A  = 4'd2;   // hx * cos
  localparam step_t ST_MUL_B  = 4'd3;   // hy * sin
  localparam step_t ST_MUL_C  = 4'd4;   // hx * sin
  localparam step_t ST_MUL_D  = 4'd5;   // hy * cos
  localparam step_t ST_MUL_X0 = 4'd6;   // world x of corners 0..3 * inverse
  localparam step_t ST_MUL_X3 = 4'd9;
  localparam step_t ST_MUL_Y0 = 4'd10;  // world y of corners 0..3 * inverse
  localparam step_t ST_MUL_Y3 = 4'd13;
  localparam step_t ST_DONE   = 4'd14;  // last NDC value lands here

  localparam vidx_t VK_LAST = VIDX_W'(VERTS_PER_RECT - 1);

  fsm_state_t state;
  fsm_state_t state_next;
  step_t      step;
  vidx_t      vk;
  count_t     count;
  inv_t       inv_w;
  inv_t       inv_h;
  rect_t      item;

  trig_t sn;
  trig_t cs;
  half_t hx;
  half_t hy;
  sum_t  sxp;
  sum_t  sxm;
  sum_t  syp;
  sum_t  sym;
  mul_a_t world;
  ndc_t  ndc_xs [4];
  ndc_t  ndc_ys [4];

  step_t prod_tag;
  logic  prod_live;
  vert_t out_q;
  logic  out_valid;

  // Handshake and control.
  logic in_ready;
  logic rect_acc;
  logic out_free;
  logic emit_load;
  logic drop_load;
  logic would_overflow;

  assign out_free = !out_valid || vert.ready;
  assign rect_acc = rect.valid && in_ready;
  assign would_overflow = ((COUNT_W + 1)'(count) + (COUNT_W + 1)'(VERTS_PER_RECT))
                          > (COUNT_W + 1)'(MAX_VERTICES);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (rect.valid && rect.data.action == ACT_DRAW) begin
          state_next = would_overflow ? ST_DROP : ST_CALC;
        end
      end
      ST_CALC: begin
        if (step == ST_DONE) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && vk == VK_LAST) state_next = ST_IDLE;
      end
      ST_DROP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    emit_load = (state == ST_EMIT) && out_free;
    drop_load = (state == ST_DROP) && out_free;
  end

  // Sine and cosine from the quarter-wave table. The quadrant swaps the two
  // lookups and sets their signs.
  logic [PHASE_PROD_W-1:0] idx_prod;
  logic [SINE_IDX_W-1:0]   idx;
  logic [SINE_IDX_W:0]     cidx_full;
  logic [TRIG_W-1:0]       t_i;
  logic [TRIG_W-1:0]       t_c;
  trig_t                   sn_next;
  trig_t                   cs_next;

  always_comb begin
    idx_prod  = PHASE_PROD_W'(item.angle[PHASE_W-1:0])
                * PHASE_PROD_W'(SINE_TABLE_DEPTH);
    idx       = idx_prod[SINE_IDX_W+PHASE_W-1:PHASE_W];
    cidx_full = (SINE_IDX_W + 1)'(SINE_TABLE_DEPTH) - (SINE_IDX_W + 1)'(idx);
    t_i       = SINE_ROM[idx];
    t_c       = (idx == '0) ? SINE_ONE : SINE_ROM[cidx_full[SINE_IDX_W-1:0]];
    case (quad_t'(item.angle[ANGLE_W-1:PHASE_W]))
      QUAD_0: begin
        sn_next = signed'(t_i);
        cs_next = signed'(t_c);
      end
      QUAD_1: begin
        sn_next = signed'(t_c);
        cs_next = -signed'(t_i);
      end
      QUAD_2: begin
        sn_next = -signed'(t_i);
        cs_next = -signed'(t_c);
      end
      default: begin
        sn_next = -signed'(t_c);
        cs_next = signed'(t_i);
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  mul_a_t mul_a;
  mul_b_t mul_b;
  prod_t  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step) inside
      ST_MUL_WX: begin
        mul_a = MUL_A_W'(item.width);
        mul_b = MUL_B_W'(item.scale_x);
      end
      ST_MUL_HY: begin
        mul_a = MUL_A_W'(item.height);
        mul_b = MUL_B_W'(item.scale_y);
      end
      ST_MUL_A: begin
        mul_a = MUL_A_W'(hx);
        mul_b = MUL_B_W'(cs);
      end
      ST_MUL_B: begin
        mul_a = MUL_A_W'(hy);
        mul_b = MUL_B_W'(sn);
      end
      ST_MUL_C: begin
        mul_a = MUL_A_W'(hx);
        mul_b = MUL_B_W'(sn);
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(hy);
        mul_b = MUL_B_W'(cs);
      end
      [ST_MUL_X0:ST_MUL_X3]: begin
        mul_a = world;
        mul_b = MUL_B_W'(inv_w);
      end
      [ST_MUL_Y0:ST_MUL_Y3]: begin
        mul_a = world;
        mul_b = MUL_B_W'(inv_h);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rrtv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Half size: round the Q32.8 product of size and scale, then halve.
  logic [HALF_PROD_W:0] half_sum;
  half_t                half_round;
  sum_t                 prod_sum;

  assign half_sum   = {1'b0, prod[HALF_PROD_W-1:0]} + HALF_ROUND;
  assign half_round = half_sum[HALF_PROD_W-1:9];
  assign prod_sum   = SUM_W'(prod);

  // World position of one corner. The center is pre-shifted into the
  // rotation's Q15 frame with the rounding half folded in, so one add and an
  // arithmetic shift give center plus the rounded rotated offset. The world
  // value is built and registered ahead of the multiply that scales it.
  step_t   wstep;
  logic    world_live;
  logic    world_is_y;
  corner_t wcorner;
  sum_t    cxk;
  sum_t    cyk;
  sum_t    wbase;
  sum_t    wpick;
  logic    wneg;
  sum_t    wsum;

  always_comb begin
    wstep      = step + step_t'(1);
    world_live = (state == ST_CALC) && (wstep >= ST_MUL_X0) && (wstep <= ST_MUL_Y3);
    world_is_y = (wstep >= ST_MUL_Y0);
    wcorner    = corner_t'(wstep - ST_MUL_X0);
    cxk        = SUM_W'(signed'({item.center_x, ROT_ROUND}));
    cyk        = SUM_W'(signed'({item.center_y, ROT_ROUND}));
    wbase      = world_is_y ? cyk : cxk;
    // Corners 0 and 2 use the difference terms for x and the sum terms
    // for y; corners 0 and 3 take them negated.
    if (wcorner[0]) begin
      wpick = world_is_y ? sym : sxp;
    end else begin
      wpick = world_is_y ? syp : sxm;
    end
    wneg = (wcorner == 2'd0) || (wcorner == 2'd3);
    wsum = wneg ? (wbase - wpick) : (wbase + wpick);
  end

  // NDC: round the Q28.32 product back to Q2.14 and saturate.
  prod_t   ndc_rsum;
  prod_t   ndc_rsh;
  ndc_t    ndc_sat;
  corner_t ndc_corner;

  always_comb begin
    ndc_rsum   = prod + NDC_ROUND;
    ndc_rsh    = ndc_rsum >>> 18;
    ndc_corner = corner_t'(prod_tag - ST_MUL_X0);
    if (ndc_rsh[PROD_W-1:NDC_W-1] == '0 || ndc_rsh[PROD_W-1:NDC_W-1] == '1) begin
      ndc_sat = ndc_rsh[NDC_W-1:0];
    end else begin
      ndc_sat = ndc_rsh[PROD_W-1] ? NDC_NEG_SAT : NDC_POS_SAT;
    end
  end

  // Next output beat: either a vertex picked by the fixed corner order or a
  // drop notice carrying only the slot and the last and dropped flags.
  vert_t out_next;

  always_comb begin
    out_next = '0;
    if (state == ST_DROP) begin
      out_next.vertex_slot  = SLOT_W'(count);
      out_next.last_of_rect = 1'b1;
      out_next.dropped      = 1'b1;
    end else begin
      out_next.ndc_x        = ndc_xs[CORNER_ORDER[vk]];
      out_next.ndc_y        = ndc_ys[CORNER_ORDER[vk]];
      out_next.red_out      = item.red_in;
      out_next.green_out    = item.green_in;
      out_next.blue_out     = item.blue_in;
      out_next.vertex_slot  = SLOT_W'(count + COUNT_W'(vk));
      out_next.last_of_rect = (vk == VK_LAST);
      out_next.dropped      = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      vk        <= '0;
      count     <= '0;
      inv_w     <= INV_W_RESET;
      inv_h     <= INV_H_RESET;
      out_valid <= 1'b0;
      prod_live <= 1'b0;
    end else begin
      state     <= state_next;
      prod_live <= (state == ST_CALC);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INV_HALF_WORLD_WIDTH:  inv_w <= cfg_data;
          REG_INV_HALF_WORLD_HEIGHT: inv_h <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CALC) begin
        step <= step + step_t'(1);
      end else begin
        step <= '0;
      end
      if (emit_load) begin
        vk <= (vk == VK_LAST) ? '0 : vk + vidx_t'(1);
      end
      if (rect_acc && rect.data.action == ACT_FRAME) begin
        count <= '0;
      end else if (emit_load && vk == VK_LAST) begin
        count <= count + COUNT_W'(VERTS_PER_RECT);
      end
      if (emit_load || drop_load) begin
        out_valid <= 1'b1;
      end else if (vert.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rect_acc) begin
      item <= rect.data;
    end
    prod_tag <= step;
    if (state == ST_CALC && step == ST_MUL_WX) begin
      sn <= sn_next;
      cs <= cs_next;
    end
    if (world_live) begin
      world <= MUL_A_W'(wsum >>> 15);
    end
    if (emit_load || drop_load) begin
      out_q <= out_next;
    end
    if (prod_live) begin
      case (prod_tag) inside
        ST_MUL_WX: hx <= half_round;
        ST_MUL_HY: hy <= half_round;
        ST_MUL_A: begin
          sxp <= prod_sum;
          sxm <= prod_sum;
        end
        ST_MUL_B: begin
          sxp <= sxp + prod_sum;
          sxm <= sxm - prod_sum;
        end
        ST_MUL_C: begin
          syp <= prod_sum;
          sym <= prod_sum;
        end
        ST_MUL_D: begin
          syp <= syp + prod_sum;
          sym <= sym - prod_sum;
        end
        [ST_MUL_X0:ST_MUL_X3]: ndc_xs[ndc_corner] <= ndc_sat;
        [ST_MUL_Y0:ST_MUL_Y3]: ndc_ys[ndc_corner] <= ndc_sat;
        default: ;
      endcase
    end
  end

  assign rect.ready = in_ready;
  assign vert.valid = out_valid;
  assign vert.data  = out_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rotated_rect_to_triangle_vertices: directed and random
// rectangle beats, an in-bench vertex predictor and a scoreboard of pending vertices.
// Depends on rrtv_pkg and the channel interfaces in rrtv_if.sv.
module testbench;
  import rrtv_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  // Idle wait after draining; it covers any work still in flight.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  // Draws offered while the receiver holds off, far more than the block can take in.
  localparam int FILL_DRAWS    = 30;
  localparam int PHASE_ITEMS   = 115;
  localparam int RECT_CORNERS [VERTS_PER_RECT] = '{0, 1, 2, 0, 2, 3};

  // Tracks the vertex count and reciprocals, expands each accepted rectangle
  // into the vertex beats it should produce, and checks beats in order.
  class vertex_scoreboard;
    int unsigned vert_count;
    inv_t        inv_w;
    inv_t        inv_h;
    longint      sine_q15 [SINE_TABLE_DEPTH+1];
    vert_t       pending_verts [$];
    int          mismatches;

    function new();
      inv_w      = INV_W_RESET;
      inv_h      = INV_H_RESET;
      vert_count = 0;
      mismatches = 0;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) sine_q15[k] = quarter_wave(k);
    endfunction

    // Eleventh-order nested Taylor sine in Q2.30, rounded to Q1.15.
    function longint quarter_wave(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned r;
      longint unsigned dens [5];
      if (k >= SINE_TABLE_DEPTH) return 32768;
      dens = '{110, 72, 42, 20, 6};
      x  = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int i = 0; i < 5; i++) t = (64'd1 << 30) - (((x2 * t) >> 30) / dens[i]);
      s = (x * t) >> 30;
      r = (s + 64'd16384) >> 15;
      return (r > 64'd32768) ? 64'sd32768 : longint'(r);
    endfunction

    function ndc_t to_ndc(longint w, inv_t inv);
      longint v;
      v = (w * longint'(inv) + 64'sd131072) >>> 18;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[NDC_W-1:0];
    endfunction

    // Appends one expected beat at the tail of the pending list.
    function void queue_vert(vert_t v);
      pending_verts = {pending_verts, v};
    endfunction

    function void note_rect(rect_t it);
      longint cx;
      longint cy;
      longint hx;
      longint hy;
      longint s_i;
      longint c_i;
      longint sn;
      longint cs;
      longint lx;
      longint ly;
      longint px [4];
      longint py [4];
      int     idx;
      vert_t  v;
      if (it.action == ACT_FRAME) begin
        vert_count = 0;
        return;
      end
      v = '0;
      // A rectangle that does not fit yields a single drop beat and leaves
      // the count where it was.
      if (vert_count + VERTS_PER_RECT > MAX_VERTICES) begin
        v.vertex_slot  = slot_t'(vert_count);
        v.last_of_rect = 1'b1;
        v.dropped      = 1'b1;
        queue_vert(v);
        return;
      end
      cx  = longint'($signed(it.center_x));
      cy  = longint'($signed(it.center_y));
      hx  = (longint'(it.width) * longint'(it.scale_x) + 64'sd256) >>> 9;
      hy  = (longint'(it.height) * longint'(it.scale_y) + 64'sd256) >>> 9;
      idx = int'(it.angle[13:0]) * SINE_TABLE_DEPTH / 16384;
      s_i = sine_q15[idx];
      c_i = sine_q15[SINE_TABLE_DEPTH - idx];
      case (quad_t'(it.angle[15:14]))
        QUAD_0: begin
          sn = s_i;
          cs = c_i;
        end
        QUAD_1: begin
          sn = c_i;
          cs = -s_i;
        end
        QUAD_2: begin
          sn = -s_i;
          cs = -c_i;
        end
        default: begin
          sn = -c_i;
          cs = s_i;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        lx    = (c == 0 || c == 3) ? -hx : hx;
        ly    = (c < 2) ? -hy : hy;
        px[c] = cx + ((lx * cs - ly * sn + 64'sd16384) >>> 15);
        py[c] = cy + ((lx * sn + ly * cs + 64'sd16384) >>> 15);
      end
      for (int k = 0; k < VERTS_PER_RECT; k++) begin
        v.ndc_x        = to_ndc(px[RECT_CORNERS[k]], inv_w);
        v.ndc_y        = to_ndc(py[RECT_CORNERS[k]], inv_h);
        v.red_out      = it.red_in;
        v.green_out    = it.green_in;
        v.blue_out     = it.blue_in;
        v.vertex_slot  = slot_t'(vert_count + k);
        v.last_of_rect = (k == VERTS_PER_RECT - 1);
        v.dropped      = 1'b0;
        queue_vert(v);
      end
      vert_count += VERTS_PER_RECT;
    endfunction

    function void log_mismatch(string what, vert_t want, vert_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected x=%0d y=%0d rgb=%h/%h/%h slot=%0d last=%b drop=%b",
                 what, want.ndc_x, want.ndc_y, want.red_out, want.green_out,
                 want.blue_out, want.vertex_slot, want.last_of_rect, want.dropped,
                 "\n    got x=%0d y=%0d rgb=%h/%h/%h slot=%0d last=%b drop=%b",
                 got.ndc_x, got.ndc_y, got.red_out, got.green_out, got.blue_out,
                 got.vertex_slot, got.last_of_rect, got.dropped);
    endfunction

    function void check_vert(vert_t got);
      vert_t want;
      if (pending_verts.size() == 0) begin
        log_mismatch("vertex beat with none pending", '0, got);
        return;
      end
      want = pending_verts.pop_front();
      if (got.ndc_x !== want.ndc_x || got.ndc_y !== want.ndc_y ||
          got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.vertex_slot !== want.vertex_slot ||
          got.last_of_rect !== want.last_of_rect || got.dropped !== want.dropped)
        log_mismatch("vertex mismatch", want, got);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_reg_t   cfg_index;
  inv_t       cfg_data;

  rrtv_rect_if rect_ch ();
  rrtv_vert_if vert_ch ();

  vertex_scoreboard tracker;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  int  cycles = 0;

  rotated_rect_to_triangle_vertices dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rect      (rect_ch),
    .vert      (vert_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off once requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      vert_ch.ready <= 1'b0;
    end else begin
      vert_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Output monitor and run-time guard.
  always @(posedge clk) begin
    cycles++;
    if (!rst && vert_ch.valid && vert_ch.ready) tracker.check_vert(vert_ch.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** rotated_rect_to_triangle_vertices: FAILED **");
      $finish;
    end
  end

  // Starts and ends at a falling edge; the beat is noted once it is taken.
  task automatic send_rect(rect_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rect_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rect_ch.valid <= 1'b1;
    rect_ch.data  <= it;
    do @(posedge clk); while (!rect_ch.ready);
    tracker.note_rect(it);
    @(negedge clk);
  endtask

  task automatic draw_rect(world_t cx, world_t cy, angle_t a, len_t w, len_t h,
                           scale_t sx, scale_t sy, color_t r, color_t g, color_t b);
    rect_t it;
    it.action   = ACT_DRAW;
    it.center_x = cx;
    it.center_y = cy;
    it.angle    = a;
    it.width    = w;
    it.height   = h;
    it.scale_x  = sx;
    it.scale_y  = sy;
    it.red_in   = r;
    it.green_in = g;
    it.blue_in  = b;
    send_rect(it);
  endtask

  // Mostly plausible scenes, some raw bit noise, some field extremes.
  function automatic rect_t random_rect(int frame_pct);
    rect_t       it;
    int unsigned style;
    style       = $urandom_range(0, 9);
    it.action   = ($urandom_range(0, 99) < frame_pct) ? ACT_FRAME : ACT_DRAW;
    it.angle    = angle_t'($urandom);
    it.red_in   = color_t'($urandom);
    it.green_in = color_t'($urandom);
    it.blue_in  = color_t'($urandom);
    if (style < 6) begin
      it.center_x = world_t'(int'($urandom_range(0, 260000)) - 130000);
      it.center_y = world_t'(int'($urandom_range(0, 260000)) - 130000);
      it.width    = len_t'($urandom_range(0, 60000));
      it.height   = len_t'($urandom_range(0, 60000));
      it.scale_x  = scale_t'($urandom_range(0, 640));
      it.scale_y  = scale_t'($urandom_range(0, 640));
    end else if (style < 9) begin
      it.center_x = world_t'($urandom);
      it.center_y = world_t'($urandom);
      it.width    = len_t'($urandom);
      it.height   = len_t'($urandom);
      it.scale_x  = scale_t'($urandom);
      it.scale_y  = scale_t'($urandom);
    end else begin
      it.center_x = $urandom_range(0, 1) ? world_t'(24'h7FFFFF) : world_t'(24'h800000);
      it.center_y = $urandom_range(0, 1) ? world_t'(24'h7FFFFF) : world_t'(24'h800000);
      it.width    = $urandom_range(0, 1) ? len_t'(24'hFFFFFF) : len_t'(0);
      it.height   = $urandom_range(0, 1) ? len_t'(24'hFFFFFF) : len_t'(0);
      it.scale_x  = $urandom_range(0, 1) ? scale_t'(16'hFFFF) : scale_t'(0);
      it.scale_y  = $urandom_range(0, 1) ? scale_t'(16'hFFFF) : scale_t'(0);
    end
    return it;
  endfunction

  // Stops offering beats, so the last one is not taken twice, then waits
  // until every expected vertex has come out.
  task automatic wait_drained();
    rect_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_verts.size() != 0);
  endtask

  // A frame beat leaves nothing to wait for, so give the block time to go idle.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(inv_t w, inv_t h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INV_HALF_WORLD_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_INV_HALF_WORLD_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we        <= 1'b0;
    tracker.inv_w = w;
    tracker.inv_h = h;
  endtask

  initial begin
    tracker       = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_INV_HALF_WORLD_WIDTH;
    cfg_data      = '0;
    rect_ch.valid = 1'b0;
    rect_ch.data  = '0;
    vert_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed beats with the reset reciprocals: every quadrant boundary,
    // the last table step, zero and full-scale sizes, saturating centers.
    send_rect(random_rect(100));
    draw_rect(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    draw_rect(0, 0, 0, 25600, 12800, 256, 256, 16'hFFFF, 16'h0000, 16'hAAAA);
    draw_rect(5120, -2560, 16384, 25600, 12800, 256, 512, 16'h1234, 16'h5678, 16'h9ABC);
    draw_rect(-5120, 2560, 32768, 25600, 12800, 384, 256, 16'h0001, 16'h8000, 16'h7FFF);
    draw_rect(1000, 1000, 49152, 25600, 12800, 256, 256, 16'h5555, 16'hAAAA, 16'h00FF);
    draw_rect(0, 0, 65535, 25600, 12800, 256, 256, 16'hFF00, 16'h0F0F, 16'hF0F0);
    draw_rect(0, 0, 1, 25600, 12800, 256, 256, 0, 0, 0);
    draw_rect(0, 0, 16383, 25600, 12800, 256, 256, 0, 0, 0);
    draw_rect(24'h7FFFFF, 24'h7FFFFF, 8192, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 16'hFFFF);
    draw_rect(24'h800000, 24'h800000, 40000, 0, 0, 0, 0, 0, 0, 0);
    draw_rect(24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
    send_rect(random_rect(100));
    draw_rect(0, 0, 0, 25600, 25600, 256, 256, 16'hC0DE, 16'hBEEF, 16'h0042);

    // A zero reciprocal pins every vertex to the origin.
    settle();
    set_config(0, 0);
    draw_rect(102400, -102400, 12345, 25600, 12800, 256, 256, 1, 2, 3);
    draw_rect(24'h7FFFFF, 24'h800000, 60000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
              4, 5, 6);

    // Full-scale reciprocals saturate almost anything off center.
    settle();
    set_config(24'hFFFFFF, 24'hFFFFFF);
    draw_rect(0, 0, 0, 0, 0, 0, 0, 7, 8, 9);
    draw_rect(2, -2, 3000, 4, 4, 256, 256, 7, 8, 9);
    draw_rect(-100000, 100000, 20000, 25600, 12800, 256, 256, 7, 8, 9);

    // Random phases, each with its own reciprocals and idling pattern.
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          set_config(inv_t'($urandom_range(0, 200000)), inv_t'($urandom_range(0, 200000)));
          send_idle_pct = 7;
          recv_idle_pct = 48;
        end
        1: begin
          set_config(inv_t'($urandom), inv_t'($urandom_range(0, 1000)));
          send_idle_pct = 48;
          recv_idle_pct = 7;
        end
        default: begin
          set_config(INV_W_RESET, INV_H_RESET);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Once, the sender stops until every pending vertex has come out.
        if (phase == 1 && i == PHASE_ITEMS / 2) wait_drained();
        send_rect(random_rect(8));
      end
    end

    // Keep offering draws while the receiver holds off for a long stretch,
    // so the block backs up into its input.
    send_rect(random_rect(100));
    hold_request = 1'b1;
    for (int i = 0; i < FILL_DRAWS; i++) send_rect(random_rect(0));
    send_rect(random_rect(100));
    for (int i = 0; i < 4; i++) send_rect(random_rect(0));

    settle();
    if (tracker.pending_verts.size() != 0)
      $display("%0d vertex beats never arrived", tracker.pending_verts.size());
    if (tracker.mismatches == 0 && tracker.pending_verts.size() == 0) begin
      $display("** rotated_rect_to_triangle_vertices: PASSED **");
    end else begin
      $display("** rotated_rect_to_triangle_vertices: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rrtv_pkg.sv
hw/rtl/rrtv_if.sv
hw/rtl/rrtv_mul.sv
hw/rtl/rotated_rect_to_triangle_vertices.sv
tb/testbench.sv
